/* sv/motor_speed_ramp_controller_unit_macros.svh */
// Assertion macros used by the checker file of the speed ramp controller.
`ifndef MOTOR_SPEED_RAMP_CONTROLLER_UNIT_MACROS_SVH
`define MOTOR_SPEED_RAMP_CONTROLLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSRC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msrc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msrc assertion failed");

`endif

/* sv/msrc_pkg.sv */
package msrc_pkg;

    localparam int DUTY_W     = 8;
    localparam int POT_W      = 10;
    localparam int TICK_W     = 16;
    localparam int STEP_W     = 8;
    localparam int CODE_W     = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int SCALED_W   = POT_W + DUTY_W;
    localparam int RECIP_W    = 19;
    localparam int PROD_W     = SCALED_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 1'b1;

    localparam logic [STEP_W-1:0] ACCEL_STEP_RST      = 8'd5;
    localparam logic [TICK_W-1:0] UPDATE_INTERVAL_RST = 16'd20;

    localparam logic [POT_W-1:0] POT_MAX = 10'd1023;

    // Exact floor division by 1023 for every product of a 10-bit value and 255.
    localparam logic [RECIP_W-1:0] RECIP_MUL   = 19'd262401;
    localparam int                 RECIP_SHIFT = 28;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_CMD  = 1'b1;

    localparam logic [CODE_W-1:0] DIR_FWD      = 2'd0;
    localparam logic [CODE_W-1:0] DIR_BWD      = 2'd1;
    localparam logic [CODE_W-1:0] DIR_STOPPING = 2'd2;
    localparam logic [CODE_W-1:0] DIR_STOP     = 2'd3;

    typedef enum logic [3:0] {
        MOT_FWD      = 4'b0001,
        MOT_BWD      = 4'b0010,
        MOT_STOPPING = 4'b0100,
        MOT_STOP     = 4'b1000
    } motion_t;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] direction;
        logic [POT_W-1:0]  pot_sample;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] pwm_duty;
        logic              pwm_side;
        logic              pwm_written;
        logic              right_enable;
        logic              left_enable;
        logic [CODE_W-1:0] motion_state;
        logic [DUTY_W-1:0] target_level;
    } result_t;

    function automatic motion_t dir_to_motion(input logic [CODE_W-1:0] dir);
        motion_t m;
        case (dir)
            DIR_FWD:      m = MOT_FWD;
            DIR_BWD:      m = MOT_BWD;
            DIR_STOPPING: m = MOT_STOPPING;
            default:      m = MOT_STOP;
        endcase
        return m;
    endfunction

    function automatic logic [CODE_W-1:0] motion_to_code(input motion_t m);
        logic [CODE_W-1:0] c;
        case (m)
            MOT_FWD:      c = DIR_FWD;
            MOT_BWD:      c = DIR_BWD;
            MOT_STOPPING: c = DIR_STOPPING;
            default:      c = DIR_STOP;
        endcase
        return c;
    endfunction

endpackage

/* sv/msrc_if.sv */
interface msrc_item_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [msrc_pkg::CODE_W-1:0]  direction;
    logic [msrc_pkg::POT_W-1:0]   pot_sample;

    modport source (output valid, mode, direction, pot_sample, input ready);
    modport sink (input valid, mode, direction, pot_sample, output ready);
endinterface

interface msrc_result_if;
    logic                         valid;
    logic                         ready;
    logic [msrc_pkg::DUTY_W-1:0]  pwm_duty;
    logic                         pwm_side;
    logic                         pwm_written;
    logic                         right_enable;
    logic                         left_enable;
    logic [msrc_pkg::CODE_W-1:0]  motion_state;
    logic [msrc_pkg::DUTY_W-1:0]  target_level;

    modport source (output valid, pwm_duty, pwm_side, pwm_written, right_enable,
                    left_enable, motion_state, target_level, input ready);
    modport sink (input valid, pwm_duty, pwm_side, pwm_written, right_enable,
                  left_enable, motion_state, target_level, output ready);
endinterface

/* sv/msrc_scale.sv */
module msrc_scale (
    input  logic [msrc_pkg::POT_W-1:0]  pot_sample,
    output logic [msrc_pkg::DUTY_W-1:0] target
);
    import msrc_pkg::*;

    logic [POT_W-1:0]    inv;
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   prod;

    // The scaled value is inv * 255, formed as inv * 256 - inv.
    assign inv    = POT_MAX - pot_sample;
    assign scaled = {inv, DUTY_W'(0)} - SCALED_W'(inv);
    assign prod   = PROD_W'(scaled) * PROD_W'(RECIP_MUL);
    assign target = prod[RECIP_SHIFT +: DUTY_W];

endmodule

/* sv/msrc_core.sv */
module msrc_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [msrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            fire,
    input  msrc_pkg::item_t                 item,
    output msrc_pkg::result_t               res
);
    import msrc_pkg::*;

    logic [STEP_W-1:0] accel_step_reg;
    logic [TICK_W-1:0] update_interval_reg;
    logic [DUTY_W-1:0] speed_now_reg, speed_now_next;
    logic [DUTY_W-1:0] speed_goal_reg, speed_goal_next;
    motion_t           motion_reg, motion_next;
    logic              side_reg, side_next;
    logic              en_right_reg, en_right_next;
    logic              en_left_reg, en_left_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;

    logic [TICK_W:0]   count_sum;
    logic [TICK_W-1:0] count;
    logic              update_due;
    logic [DUTY_W-1:0] pot_target;
    logic [DUTY_W-1:0] goal_tick;
    logic [DUTY_W:0]   up_sum;
    logic [DUTY_W:0]   dn_lim;
    logic [DUTY_W-1:0] up_val;
    logic [DUTY_W-1:0] dn_val;
    logic [DUTY_W-1:0] ramped;
    logic              written;

    msrc_scale u_scale (
        .pot_sample (item.pot_sample),
        .target     (pot_target)
    );

    assign count_sum  = {1'b0, ticks_reg} + (TICK_W + 1)'(1);
    assign count      = count_sum[TICK_W] ? '1 : count_sum[TICK_W-1:0];
    assign update_due = (count >= update_interval_reg);
    assign goal_tick  = (motion_reg == MOT_STOPPING) ? '0 : pot_target;

    // The speed moves toward the new goal and never passes it.
    assign up_sum = {1'b0, speed_now_reg} + {1'b0, accel_step_reg};
    assign dn_lim = {1'b0, goal_tick} + {1'b0, accel_step_reg};
    assign up_val = (up_sum > {1'b0, goal_tick}) ? goal_tick : up_sum[DUTY_W-1:0];
    assign dn_val = ({1'b0, speed_now_reg} < dn_lim) ? goal_tick
                                                      : speed_now_reg - accel_step_reg;
    assign ramped = (speed_now_reg < goal_tick) ? up_val :
                    (speed_now_reg > goal_tick) ? dn_val : speed_now_reg;

    always_comb
    begin
        speed_now_next  = speed_now_reg;
        speed_goal_next = speed_goal_reg;
        motion_next     = motion_reg;
        side_next       = side_reg;
        en_right_next   = en_right_reg;
        en_left_next    = en_left_reg;
        ticks_next      = ticks_reg;
        written         = 1'b0;
        if (fire)
        begin
            if (item.mode == MODE_CMD)
            begin
                motion_next = dir_to_motion(item.direction);
                case (item.direction)
                    DIR_FWD:
                    begin
                        side_next     = 1'b0;
                        en_right_next = 1'b1;
                    end
                    DIR_BWD:
                    begin
                        side_next    = 1'b1;
                        en_left_next = 1'b1;
                    end
                    DIR_STOPPING:
                    begin
                        speed_goal_next = '0;
                    end
                    DIR_STOP:
                    begin
                        en_right_next = 1'b0;
                        en_left_next  = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (!update_due)
            begin
                ticks_next = count;
            end
            else
            begin
                ticks_next      = '0;
                speed_goal_next = goal_tick;
                if (motion_reg != MOT_STOP)
                begin
                    speed_now_next = ramped;
                    written        = 1'b1;
                    if (ramped == '0)
                    begin
                        motion_next = MOT_STOP;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_step_reg      <= ACCEL_STEP_RST;
            update_interval_reg <= UPDATE_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACCEL_STEP:      accel_step_reg      <= cfg_wdata[STEP_W-1:0];
                CFG_UPDATE_INTERVAL: update_interval_reg <= cfg_wdata[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_now_reg  <= '0;
            speed_goal_reg <= '0;
            motion_reg     <= MOT_STOP;
            side_reg       <= 1'b0;
            en_right_reg   <= 1'b0;
            en_left_reg    <= 1'b0;
            ticks_reg      <= '0;
        end
        else
        begin
            speed_now_reg  <= speed_now_next;
            speed_goal_reg <= speed_goal_next;
            motion_reg     <= motion_next;
            side_reg       <= side_next;
            en_right_reg   <= en_right_next;
            en_left_reg    <= en_left_next;
            ticks_reg      <= ticks_next;
        end
    end

    assign res.pwm_duty     = speed_now_next;
    assign res.pwm_side     = side_next;
    assign res.pwm_written  = written;
    assign res.right_enable = en_right_next;
    assign res.left_enable  = en_left_next;
    assign res.motion_state = motion_to_code(motion_next);
    assign res.target_level = speed_goal_next;

endmodule

/* sv/motor_speed_ramp_controller_unit.sv */
// Speed ramp controller for a PWM H-bridge. Each transfer on the item channel is either a
// millisecond tick with a potentiometer sample or a direction command, and each one yields
// exactly one transfer on the result channel with the duty, side, bridge enables, motion
// state and target after that item. An item is registered on entry and processed once the
// result register is free, when the tick counter, the target scaler (one constant multiply)
// and the ramp step update the state and load the result register; its result is offered from
// the cycle after that. One item is taken in every cycle as long as results are taken.
// Configuration writes take effect at once and should be made only while no transfer is
// in flight.
module motor_speed_ramp_controller_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [msrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    msrc_item_if.sink                       item,
    msrc_result_if.source                   result
);
    import msrc_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t res;
    logic    advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    msrc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .item      (in_item_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg.mode       <= item.mode;
            in_item_reg.direction  <= item.direction;
            in_item_reg.pot_sample <= item.pot_sample;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.pwm_duty     = out_res_reg.pwm_duty;
    assign result.pwm_side     = out_res_reg.pwm_side;
    assign result.pwm_written  = out_res_reg.pwm_written;
    assign result.right_enable = out_res_reg.right_enable;
    assign result.left_enable  = out_res_reg.left_enable;
    assign result.motion_state = out_res_reg.motion_state;
    assign result.target_level = out_res_reg.target_level;

endmodule

/* sv/msrc_checker.sv */
`include "motor_speed_ramp_controller_unit_macros.svh"

module msrc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [msrc_pkg::DUTY_W-1:0]     res_duty,
    input logic                            res_side,
    input logic                            res_written,
    input logic                            res_right,
    input logic                            res_left,
    input logic [msrc_pkg::CODE_W-1:0]     res_motion,
    input logic [msrc_pkg::DUTY_W-1:0]     res_target
);
    import msrc_pkg::*;

    // A stalled transfer on the result channel keeps its payload.
    `MSRC_ASSERT_NEXT(a_result_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable({res_duty, res_side, res_written, res_right, res_left, res_motion, res_target}))

    // A ramp update enters stop exactly when it brings the speed to zero.
    `MSRC_ASSERT_IMPLIES(a_written_stop, clk, rst_n, res_valid && res_written, (res_duty == '0) == (res_motion == DIR_STOP))

    // The stopping state always carries a zero target.
    `MSRC_ASSERT_IMPLIES(a_stopping_target, clk, rst_n, res_valid && (res_motion == DIR_STOPPING), res_target == '0)

    // Forward and backward motion keep their side selected and its bridge enabled.
    `MSRC_ASSERT_IMPLIES(a_forward_side, clk, rst_n, res_valid && (res_motion == DIR_FWD), res_right && !res_side)
    `MSRC_ASSERT_IMPLIES(a_backward_side, clk, rst_n, res_valid && (res_motion == DIR_BWD), res_left && res_side)

endmodule

bind motor_speed_ramp_controller_unit msrc_checker u_msrc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_duty    (result.pwm_duty),
    .res_side    (result.pwm_side),
    .res_written (result.pwm_written),
    .res_right   (result.right_enable),
    .res_left    (result.left_enable),
    .res_motion  (result.motion_state),
    .res_target  (result.target_level)
);
